/* hw/rtl/pve_pkg.sv */
`default_nettype none
package pve_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int SLOPE_SH    = 16;
  localparam int STEP_SH     = 15;

  localparam logic [1:0] ST_VERTEX = 2'd0;
  localparam logic [1:0] ST_CLAMP  = 2'd1;
  localparam logic [1:0] ST_DEGEN  = 2'd2;
  localparam logic [1:0] ST_CONVEX = 2'd3;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] second_x;
    logic signed [31:0] third_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_y;
    logic signed [31:0] third_y;
  } pve_in_t;

  typedef struct packed {
    logic signed [31:0] best_x;
    logic [1:0]         status;
  } pve_out_t;

  typedef struct packed {
    logic signed [32:0] dy2;
    logic signed [32:0] dx2;
    logic signed [32:0] dy3;
    logic signed [32:0] dx3;
    logic signed [32:0] dx23;
    logic signed [31:0] mid;
    logic signed [31:0] x1;
    logic signed [31:0] xmax;
    logic               coinc;
  } pve_item_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sext33(input logic signed [32:0] v);
    return {{31{v[32]}}, v};
  endfunction

  // trunc((a + b) / 2)
  function automatic logic signed [31:0] half_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [32:0] t;
    s = {a[31], a} + {b[31], b};
    t = s + {32'd0, s[32]};
    return t[32:1];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/parabolic_vertex_estimate_unit.sv */
// path: from input transaction to result through the queue, the three
// chained bit-serial divider pipelines (80, 80 and 79 quotient stages, each
// with an input and an output register) and the output register
// throughput: one transaction per cycle; the whole back end stalls only while a result waits
// reset: synchronous, active high; clears queue, pipeline valids and lower_bound to 0
`default_nettype none
module parabolic_vertex_estimate_unit #(
  parameter int QUEUE_DEPTH = pve_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pve_pkg::pve_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pve_pkg::pve_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import pve_pkg::*;

  logic signed [31:0] lower_bound;
  pve_item_t          f_item;
  pve_item_t          q_item;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  logic               back_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
    end else if (cfg_valid && cfg_ready) begin
      lower_bound <= cfg_data;
    end
  end

  pve_front u_front (
    .pts (in_data),
    .item(f_item)
  );

  assign pop      = back_ready && !q_empty;
  assign in_ready = !q_full || pop;

  pve_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .push (in_valid && in_ready),
    .wdata(f_item),
    .pop,
    .full (q_full),
    .empty(q_empty),
    .rdata(q_item)
  );

  pve_back u_back (
    .clk, .rst,
    .item_valid (!q_empty),
    .item       (q_item),
    .item_ready (back_ready),
    .lower_bound,
    .out_valid,
    .out_ready,
    .out_data
  );

  a_idle_after_reset : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_only_on_output : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back pressure");

endmodule
`default_nettype wire

/* hw/rtl/pve_front.sv */
`default_nettype none
module pve_front (
  input  pve_pkg::pve_in_t   pts,
  output pve_pkg::pve_item_t item
);
  import pve_pkg::*;

  logic signed [31:0] xm;
  logic signed [31:0] ym;

  always_comb begin
    xm = pts.second_x;
    ym = pts.second_y;
    if (pts.first_y > ym) begin
      xm = pts.first_x;
      ym = pts.first_y;
    end
    if (pts.third_y > ym) begin
      xm = pts.third_x;
    end
    item.xmax  = xm;
    item.coinc = (pts.first_x == pts.second_x) || (pts.first_x == pts.third_x) ||
                 (pts.second_x == pts.third_x);
    item.dy2   = {pts.first_y[31], pts.first_y} - {pts.second_y[31], pts.second_y};
    item.dx2   = {pts.first_x[31], pts.first_x} - {pts.second_x[31], pts.second_x};
    item.dy3   = {pts.first_y[31], pts.first_y} - {pts.third_y[31], pts.third_y};
    item.dx3   = {pts.first_x[31], pts.first_x} - {pts.third_x[31], pts.third_x};
    item.dx23  = {pts.second_x[31], pts.second_x} - {pts.third_x[31], pts.third_x};
    item.mid   = half_sum(pts.first_x, pts.second_x);
    item.x1    = pts.first_x;
  end

endmodule
`default_nettype wire

/* hw/rtl/pve_fifo.sv */
`default_nettype none
module pve_fifo #(
  parameter int DEPTH = pve_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pve_pkg::pve_item_t  wdata,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output pve_pkg::pve_item_t  rdata
);
  import pve_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pve_item_t       mem [0:DEPTH-1];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pve_div.sv */
`default_nettype none
module pve_div #(
  parameter int SH = pve_pkg::SLOPE_SH,
  parameter int PW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [63:0]  num,
  input  logic signed [63:0]  den,
  input  logic [PW-1:0]       in_pl,
  output logic                out_valid,
  output logic signed [63:0]  quo,
  output logic [PW-1:0]       out_pl
);
  import pve_pkg::*;

  localparam int N  = 64 + SH;
  localparam int QW = 64 + SH;

  logic            v  [0:N];
  logic [63:0]     r  [0:N];
  logic [QW-1:0]   q  [0:N];
  logic [63:0]     n  [0:N];
  logic [63:0]     d  [0:N];
  logic            ng [0:N];
  logic [PW-1:0]   pl [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n[0]  <= mag64(num);
      d[0]  <= mag64(den);
      ng[0] <= num[63] ^ den[63];
      r[0]  <= '0;
      q[0]  <= '0;
      pl[0] <= in_pl;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic        nb;
    logic [63:0] rs;
    logic        ge;
    if (N - k >= SH) begin : g_bit
      assign nb = n[k-1][N-k-SH];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign rs = {r[k-1][62:0], nb};
    assign ge = (rs >= d[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[k]  <= ge ? rs - d[k-1] : rs;
        q[k]  <= {q[k-1][QW-2:0], ge};
        n[k]  <= n[k-1];
        d[k]  <= d[k-1];
        ng[k] <= ng[k-1];
        pl[k] <= pl[k-1];
      end
    end
  end

  logic              big;
  logic signed [63:0] sat;

  always_comb begin
    big = |q[N][QW-1:63];
    if (ng[N]) begin
      sat = big ? {1'b1, 63'd0} : 64'(-q[N][63:0]);
    end else begin
      sat = big ? {1'b0, {63{1'b1}}} : q[N][63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo    <= sat;
      out_pl <= pl[N];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pve_back.sv */
`default_nettype none
module pve_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  pve_pkg::pve_item_t  item,
  output logic                item_ready,
  input  logic signed [31:0]  lower_bound,
  output logic                out_valid,
  input  logic                out_ready,
  output pve_pkg::pve_out_t   out_data
);
  import pve_pkg::*;

  typedef struct packed {
    pve_item_t          item;
    logic signed [63:0] s2;
    logic               eq;
  } pve_curv_t;

  typedef struct packed {
    pve_item_t item;
    logic      eq;
    logic      cz;
    logic      cpos;
  } pve_step_t;

  logic               en;
  logic               s2_valid;
  logic signed [63:0] s2;
  logic signed [63:0] s3;
  pve_item_t          s_item;
  logic               c_valid;
  logic signed [63:0] curv;
  pve_curv_t          c_in;
  pve_curv_t          c_pl;
  pve_step_t          t_in;
  logic               t_valid;
  logic signed [63:0] step;
  pve_step_t          t_pl;

  assign en         = !out_valid || out_ready;
  assign item_ready = en;

  pve_div #(.SH(SLOPE_SH), .PW($bits(pve_item_t))) u_div_s2 (
    .clk, .rst, .en,
    .in_valid (item_valid),
    .num      (sext33(item.dy2)),
    .den      (sext33(item.dx2)),
    .in_pl    (item),
    .out_valid(s2_valid),
    .quo      (s2),
    .out_pl   (s_item)
  );

  pve_div #(.SH(SLOPE_SH), .PW(1)) u_div_s3 (
    .clk, .rst, .en,
    .in_valid (item_valid),
    .num      (sext33(item.dy3)),
    .den      (sext33(item.dx3)),
    .in_pl    (1'b0),
    .out_valid(),
    .quo      (s3),
    .out_pl   ()
  );

  assign c_in.item = s_item;
  assign c_in.s2   = s2;
  assign c_in.eq   = (s2 == s3);

  pve_div #(.SH(SLOPE_SH), .PW($bits(pve_curv_t))) u_div_curv (
    .clk, .rst, .en,
    .in_valid (s2_valid),
    .num      (s2 - s3),
    .den      (sext33(s_item.dx23)),
    .in_pl    (c_in),
    .out_valid(c_valid),
    .quo      (curv),
    .out_pl   (c_pl)
  );

  assign t_in.item = c_pl.item;
  assign t_in.eq   = c_pl.eq;
  assign t_in.cz   = (curv == '0);
  assign t_in.cpos = !curv[63] && (curv != '0);

  pve_div #(.SH(STEP_SH), .PW($bits(pve_step_t))) u_div_step (
    .clk, .rst, .en,
    .in_valid (c_valid),
    .num      (c_pl.s2),
    .den      (curv),
    .in_pl    (t_in),
    .out_valid(t_valid),
    .quo      (step),
    .out_pl   (t_pl)
  );

  logic signed [64:0] dv;
  logic signed [63:0] vtx;
  logic signed [63:0] lb64;
  pve_out_t           res;

  always_comb begin
    dv   = {{33{t_pl.item.mid[31]}}, t_pl.item.mid} - {step[63], step};
    lb64 = {{32{lower_bound[31]}}, lower_bound};
    if (dv[64] != dv[63]) begin
      vtx = dv[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      vtx = dv[63:0];
    end
    if (t_pl.item.coinc || t_pl.eq || t_pl.cz) begin
      res.best_x = t_pl.item.xmax;
      res.status = ST_DEGEN;
    end else if (t_pl.cpos) begin
      res.best_x = t_pl.item.xmax;
      res.status = ST_CONVEX;
    end else if (vtx < lb64) begin
      res.best_x = half_sum(t_pl.item.x1, lower_bound);
      res.status = ST_CLAMP;
    end else begin
      if (vtx > 64'sh7fffffff) begin
        res.best_x = 32'sh7fffffff;
      end else if (vtx < -64'sh80000000) begin
        res.best_x = 32'sh80000000;
      end else begin
        res.best_x = vtx[31:0];
      end
      res.status = ST_VERTEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
module tb;
  import pve_pkg::*;

  localparam int  SETTLE_CYCLES = 320;
  localparam int  CYCLE_LIMIT   = 2000000;
  localparam int  PHASE_ITEMS   = 200;
  localparam int  NUM_PHASES    = 5;
  localparam int  NUM_ROWS      = 12;
  localparam int  Q1            = 65536;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pve_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pve_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [31:0] cfg_data = '0;

  longint   bound_model;
  pve_out_t vertex_fifo[$];
  int       errors = 0;
  int       accepted = 0;
  int       cycles = 0;
  int       burst_left = 0;

  typedef struct {
    pve_in_t  pts;
    bit       known;
    pve_out_t want;
  } row_t;
  row_t rows[NUM_ROWS];

  parabolic_vertex_estimate_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // trunc(num * 2^sh / den), saturated to 64 bit
  function automatic longint fixed_quot(input longint num, input longint den, input int sh);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    n = {64'd0, num < 0 ? 64'(-num) : 64'(num)} << sh;
    d = {64'd0, den < 0 ? 64'(-den) : 64'(den)};
    q = n / d;
    if ((num < 0) == (den < 0))
      return (q > 128'h7fffffffffffffff) ? 64'h7fffffffffffffff : longint'(q[63:0]);
    return (q >= 128'h8000000000000000) ? 64'h8000000000000000 : -longint'(q[63:0]);
  endfunction

  function automatic pve_out_t predict_vertex(input pve_in_t p, input longint lb);
    longint x1, x2, x3, y1, y2, y3, xm, ym, s2, s3, curv, mid, stp, vtx;
    pve_out_t r;
    x1 = p.first_x; x2 = p.second_x; x3 = p.third_x;
    y1 = p.first_y; y2 = p.second_y; y3 = p.third_y;
    xm = x2; ym = y2;
    if (y1 > ym) begin
      ym = y1;
      xm = x1;
    end
    if (y3 > ym) xm = x3;
    r.best_x = 32'(xm);
    r.status = ST_DEGEN;
    if (x1 == x2 || x1 == x3 || x2 == x3) return r;
    s2 = fixed_quot(y1 - y2, x1 - x2, SLOPE_SH);
    s3 = fixed_quot(y1 - y3, x1 - x3, SLOPE_SH);
    if (s2 == s3) return r;
    curv = fixed_quot(s2 - s3, x2 - x3, SLOPE_SH);
    if (curv == 0) return r;
    if (curv > 0) begin
      r.status = ST_CONVEX;
      return r;
    end
    mid = (x1 + x2) / 2;
    stp = fixed_quot(s2, curv, STEP_SH);
    if (stp > 0 && mid < -64'sh7fffffffffffffff - 1 + stp) vtx = 64'sh8000000000000000;
    else if (stp < 0 && mid > 64'sh7fffffffffffffff + stp) vtx = 64'sh7fffffffffffffff;
    else vtx = mid - stp;
    if (vtx < lb) begin
      r.best_x = 32'((x1 + lb) / 2);
      r.status = ST_CLAMP;
      return r;
    end
    if (vtx > 64'sh7fffffff) vtx = 64'sh7fffffff;
    if (vtx < -64'sh80000000) vtx = -64'sh80000000;
    r.best_x = 32'(vtx);
    r.status = ST_VERTEX;
    return r;
  endfunction

  // transaction monitor and checker
  always @(posedge clk) begin
    pve_out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) bound_model = longint'($signed(cfg_data));
      if (in_valid && in_ready) begin
        vertex_fifo.push_back(predict_vertex(in_data, bound_model));
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (vertex_fifo.size() == 0) begin
          $display("%0t: unexpected result best_x=%h status=%0d",
                   $time, out_data.best_x, out_data.status);
          errors++;
        end else begin
          want = vertex_fifo.pop_front();
          if (out_data.best_x !== want.best_x || out_data.status !== want.status) begin
            $display("%0t: mismatch expected best_x=%h status=%0d actual best_x=%h status=%0d",
                     $time, want.best_x, want.status, out_data.best_x, out_data.status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off
  initial begin
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && accepted >= 300) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (1200) @(negedge clk);
      end else if ((cycles / 500) % 3 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_bound(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_points(input pve_in_t p);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (vertex_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pve_in_t rand_points();
    pve_in_t p;
    int sc, k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      // concave triple around a random center
      sc = 1 << $urandom_range(4, 22);
      p.second_x = $urandom_range(0, 32'h7fffff) - 32'h400000;
      p.first_x  = p.second_x - $urandom_range(1, sc);
      p.third_x  = p.second_x + $urandom_range(1, sc);
      p.second_y = $urandom_range(0, 32'hffff) + $urandom_range(0, sc);
      p.first_y  = p.second_y - $urandom_range(0, sc);
      p.third_y  = p.second_y - $urandom_range(0, sc);
      if ($urandom_range(0, 1)) begin
        p.first_x = p.third_x;
        p.third_x = p.second_x - $urandom_range(1, sc);
      end
    end else if (k < 8) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (k == 8) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p.third_x = $urandom_range(0, 1) ? p.first_x : p.second_x;
    end else begin
      sc = $urandom_range(1, 64) * Q1;
      p.first_x  = -sc; p.second_x = 0; p.third_x = sc;
      p.first_y  = $urandom_range(0, 8) * Q1;
      p.second_y = $urandom_range(0, 8) * Q1;
      p.third_y  = $urandom_range(0, 8) * Q1;
    end
    return p;
  endfunction

  function automatic row_t mk(input int x1, x2, x3, y1, y2, y3,
                              input bit kn, input int bx, input logic [1:0] st);
    row_t r;
    r.pts = '{first_x:x1, second_x:x2, third_x:x3, first_y:y1, second_y:y2, third_y:y3};
    r.known = kn;
    r.want.best_x = bx;
    r.want.status = st;
    return r;
  endfunction

  initial begin
    logic [31:0] bounds[NUM_PHASES];
    rows[0]  = mk(0, 0, 0, 0, 0, 0, 1, 0, ST_DEGEN);
    rows[1]  = mk(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, ST_DEGEN);
    rows[2]  = mk(5, 7, 5, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 7, ST_DEGEN);
    rows[3]  = mk(0, Q1, 2 * Q1, 0, Q1, 2 * Q1, 1, 2 * Q1, ST_DEGEN);
    rows[4]  = mk(-Q1, 0, Q1, Q1, 0, Q1, 1, -Q1, ST_CONVEX);
    rows[5]  = mk(-Q1, 0, Q1, -Q1, 0, -Q1, 0, 0, ST_VERTEX);
    rows[6]  = mk(-3 * Q1, -2 * Q1, -Q1, -4 * Q1, -Q1, 0, 0, 0, ST_VERTEX);
    rows[7]  = mk(32'h80000000, 0, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, ST_VERTEX);
    rows[8]  = mk(32'h7fffffff, 32'h80000000, 0,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, ST_VERTEX);
    rows[9]  = mk(0, 1, 2, 0, 1, 0, 0, 0, ST_VERTEX);
    rows[10] = mk(0, 1, 3, 0, 0, 1, 0, 0, ST_VERTEX);
    rows[11] = mk(-Q1, 2 * Q1, 5 * Q1, -9 * Q1, 0, -9 * Q1, 0, 0, ST_VERTEX);
    bounds = '{32'h80000000, 32'h7fffffff, 32'hfff00000, 32'h00010000, $urandom};
    bound_model = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_points(rows[i].pts);
      if (rows[i].known && predict_vertex(rows[i].pts, bound_model) != rows[i].want) begin
        $display("%0t: mismatch expected best_x=%h status=%0d on directed row %0d",
                 $time, rows[i].want.best_x, rows[i].want.status, i);
        errors++;
      end
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_bound(bounds[ph]);
      if (ph == 2) begin
        foreach (rows[i]) send_points(rows[i].pts);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_points(rand_points());
      drain();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
